### src/eilc_pkg.sv
// Package for the edge interrupt line controller.
// Request and result types, opcodes, register offsets and status codes.
// No dependencies.
`timescale 1ns / 1ps

package eilc_pkg;

  localparam int unsigned NumLinesDefault = 16;
  localparam int unsigned PortFields      = 16;
  localparam int unsigned PortW           = 4;
  localparam int unsigned CfgIdxW         = 1;
  localparam int unsigned CfgDataW        = 64;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EDGE  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNALIGNED = 2'd1;
  localparam logic [1:0] ST_FAULT     = 2'd2;

  localparam logic [9:0] OFF_LINE_MASK  = 10'h000;
  localparam logic [9:0] OFF_EVENT_MASK = 10'h004;
  localparam logic [9:0] OFF_RISING     = 10'h008;
  localparam logic [9:0] OFF_FALLING    = 10'h00C;
  localparam logic [9:0] OFF_SWTRIG     = 10'h010;
  localparam logic [9:0] OFF_PENDING    = 10'h014;

  localparam logic [CfgIdxW-1:0] CFG_PORT_CHECK = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PORT_MAP   = 1'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [9:0]  reg_offset;
    logic        word_access;
    logic [31:0] write_data;
    logic [7:0]  edge_pin;
    logic [3:0]  edge_port;
    logic        edge_rising;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
    logic [15:0] triggered_lines;
  } res_t;

endpackage

### src/eilc_stage.sv
// Valid/ready pipeline register holding one request or result.
// Payload type given by parameter; no package dependency.
`timescale 1ns / 1ps

module eilc_stage #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  T     in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output T     out_data_o
);

  logic valid_q, valid_d;
  T     data_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

endmodule

### src/eilc_core.sv
// Register file and request evaluation of the edge interrupt line controller.
// Uses eilc_pkg types and codes; state updates on fired requests and cfg_we_i.
`timescale 1ns / 1ps

module eilc_core #(
  parameter int unsigned NumLines = eilc_pkg::NumLinesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [eilc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [eilc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          fire_i,
  input  eilc_pkg::req_t                req_i,
  output eilc_pkg::res_t                res_o
);

  localparam logic [31:0] LinesAll = 32'((64'h1 << NumLines) - 64'h1);

  logic                                                  port_check_q;
  logic [eilc_pkg::PortFields-1:0][eilc_pkg::PortW-1:0] port_map_q;
  logic [31:0] line_mask_q, line_mask_d;
  logic [31:0] event_mask_q, event_mask_d;
  logic [31:0] rising_q, rising_d;
  logic [31:0] falling_q, falling_d;
  logic [31:0] swtrig_q, swtrig_d;
  logic [NumLines-1:0] pending_q, pending_d;

  logic [31:0] pend_ext;
  logic [31:0] trig;
  logic [31:0] bit_sel;
  logic [31:0] en_sel;
  logic [eilc_pkg::PortW-1:0] line_port;
  logic        pin_ok;
  logic        port_ok;

  assign pend_ext  = 32'(pending_q);
  assign pin_ok    = req_i.edge_pin < 8'(NumLines);
  assign bit_sel   = 32'h1 << req_i.edge_pin[4:0];
  assign en_sel    = req_i.edge_rising ? rising_q : falling_q;
  assign line_port = (req_i.edge_pin[7:4] == 4'd0) ? port_map_q[req_i.edge_pin[3:0]]
                                                   : '0;
  assign port_ok   = !port_check_q || (req_i.edge_port == line_port);

  always_comb begin
    line_mask_d  = line_mask_q;
    event_mask_d = event_mask_q;
    rising_d     = rising_q;
    falling_d    = falling_q;
    swtrig_d     = swtrig_q;
    pending_d    = pending_q;
    trig         = '0;
    res_o        = '0;
    unique case (req_i.opcode)
      eilc_pkg::OP_READ: begin
        if (!req_i.word_access) begin
          res_o.status = eilc_pkg::ST_UNALIGNED;
        end else begin
          unique case (req_i.reg_offset)
            eilc_pkg::OFF_LINE_MASK:  res_o.read_data = line_mask_q;
            eilc_pkg::OFF_EVENT_MASK: res_o.read_data = event_mask_q;
            eilc_pkg::OFF_RISING:     res_o.read_data = rising_q;
            eilc_pkg::OFF_FALLING:    res_o.read_data = falling_q;
            eilc_pkg::OFF_SWTRIG:     res_o.read_data = swtrig_q;
            eilc_pkg::OFF_PENDING:    res_o.read_data = pend_ext;
            default:                  res_o.status    = eilc_pkg::ST_FAULT;
          endcase
        end
      end
      eilc_pkg::OP_WRITE: begin
        if (!req_i.word_access) begin
          res_o.status = eilc_pkg::ST_UNALIGNED;
        end else begin
          unique case (req_i.reg_offset)
            eilc_pkg::OFF_LINE_MASK:  line_mask_d  = req_i.write_data;
            eilc_pkg::OFF_EVENT_MASK: event_mask_d = req_i.write_data;
            eilc_pkg::OFF_RISING:     rising_d     = req_i.write_data;
            eilc_pkg::OFF_FALLING:    falling_d    = req_i.write_data;
            eilc_pkg::OFF_SWTRIG: begin
              swtrig_d  = req_i.write_data;
              trig      = req_i.write_data & line_mask_q & ~pend_ext & LinesAll;
              pending_d = pending_q | trig[NumLines-1:0];
            end
            eilc_pkg::OFF_PENDING:
              pending_d = pending_q & ~req_i.write_data[NumLines-1:0];
            default: res_o.status = eilc_pkg::ST_FAULT;
          endcase
        end
      end
      eilc_pkg::OP_EDGE: begin
        if (pin_ok && port_ok && ((line_mask_q & en_sel & bit_sel) != '0)) begin
          trig      = bit_sel;
          pending_d = pending_q | trig[NumLines-1:0];
        end
      end
      default: ;
    endcase
    res_o.triggered_lines = trig[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_check_q <= 1'b1;
      port_map_q   <= '0;
      line_mask_q  <= '0;
      event_mask_q <= '0;
      rising_q     <= '0;
      falling_q    <= '0;
      swtrig_q     <= '0;
      pending_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          eilc_pkg::CFG_PORT_CHECK: port_check_q <= cfg_data_i[0];
          eilc_pkg::CFG_PORT_MAP:   port_map_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire_i) begin
        line_mask_q  <= line_mask_d;
        event_mask_q <= event_mask_d;
        rising_q     <= rising_d;
        falling_q    <= falling_d;
        swtrig_q     <= swtrig_d;
        pending_q    <= pending_d;
      end
    end
  end

endmodule

### src/edge_interrupt_line_controller_unit.sv
// Top level of the edge interrupt line controller: input register, core, result register.
// Depends on eilc_pkg, eilc_stage and eilc_core.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   request  | in_valid_i / in_ready_o    | in_req_i  (eilc_pkg::req_t)
//   result   | out_valid_o / out_ready_i  | out_res_o (eilc_pkg::res_t)
//   config   | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// One request per cycle sustained while out_ready_i is high; a request passes from the input
// register through the core into the result register, where its result becomes valid.
// Non-config registers update as a request moves from the input into the result register.
// A stalled result holds the result register, and the input register once it is full;
// reset empties both, clears the other registers and sets port checking on.
`timescale 1ns / 1ps

module edge_interrupt_line_controller_unit #(
  parameter int unsigned NumLines = eilc_pkg::NumLinesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [eilc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [eilc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  eilc_pkg::req_t                in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output eilc_pkg::res_t                out_res_o
);

  logic           req_valid;
  logic           res_ready;
  logic           fire;
  eilc_pkg::req_t req;
  eilc_pkg::res_t res;

  assign fire = req_valid && res_ready;

  eilc_stage #(.T(eilc_pkg::req_t)) u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_req_i),
    .out_valid_o(req_valid),
    .out_ready_i(res_ready),
    .out_data_o (req)
  );

  eilc_core #(.NumLines(NumLines)) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .req_i      (req),
    .res_o      (res)
  );

  eilc_stage #(.T(eilc_pkg::res_t)) u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_o (res_ready),
    .in_data_i  (res),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_res_o)
  );

endmodule
